// ===== sv/riscv_decode_stage_unit_defines.svh =====
// Assertion macros for the checker file of the decode stage.
`ifndef RISCV_DECODE_STAGE_UNIT_DEFINES_SVH
`define RISCV_DECODE_STAGE_UNIT_DEFINES_SVH

// Checked out of reset only.
`define RVDS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked while reset is held.
`define RVDS_ASSERT_IN_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |-> (prop)) else $error(msg);

`endif

// ===== sv/rvds_pkg.sv =====
// Shared types and constants of the RISC-V decode stage.
package rvds_pkg;

  localparam int unsigned XLEN   = 32;
  localparam int unsigned NREG   = 32;
  localparam int unsigned REG_AW = 5;

  // Major opcodes, instruction bits 6..2.
  localparam logic [4:0] OPC_LOAD     = 5'd0;
  localparam logic [4:0] OPC_LOAD_FP  = 5'd1;
  localparam logic [4:0] OPC_MISC_MEM = 5'd3;
  localparam logic [4:0] OPC_OP_IMM   = 5'd4;
  localparam logic [4:0] OPC_AUIPC    = 5'd5;
  localparam logic [4:0] OPC_STORE    = 5'd8;
  localparam logic [4:0] OPC_STORE_FP = 5'd9;
  localparam logic [4:0] OPC_OP       = 5'd12;
  localparam logic [4:0] OPC_LUI      = 5'd13;
  localparam logic [4:0] OPC_OP_FP    = 5'd20;
  localparam logic [4:0] OPC_BRANCH   = 5'd24;
  localparam logic [4:0] OPC_JALR     = 5'd25;
  localparam logic [4:0] OPC_JAL      = 5'd27;
  localparam logic [4:0] OPC_SYSTEM   = 5'd28;

  // Branch funct3.
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // Shift funct3 that take the alternate bit on OP-IMM.
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_SRX = 3'd5;

  localparam logic [4:0]      ALU_ADD   = 5'd0;
  localparam logic [4:0]      ALU_OR    = 5'd6;
  localparam logic [3:0]      MEM_NONE  = 4'd15;
  localparam logic [3:0]      MEM_STORE = 4'd8;
  localparam logic [XLEN-1:0] LINK_STEP = 32'd4;
  localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
  localparam logic [REG_AW-1:0] REG_SYS  = 5'd31;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

  typedef struct packed {
    logic [XLEN-1:0] instr;
    logic [XLEN-1:0] pc;
    logic [XLEN-1:0] rs1_val;
    logic [XLEN-1:0] rs2_val;
    logic [NREG-1:0] pending;
    logic            eh1;
    logic            eh2;
    logic            empty;
  } dec_req_t;

  typedef struct packed {
    logic              stall;
    logic              flush;
    logic [XLEN-1:0]   target;
    logic [XLEN-1:0]   opa;
    logic [XLEN-1:0]   opb;
    logic [XLEN-1:0]   store_val;
    logic [REG_AW-1:0] dest;
    logic              we;
    logic [4:0]        alu;
    logic [3:0]        mem;
    logic              flt;
    logic              illegal;
  } dec_res_t;

endpackage

// ===== sv/rvds_in_if.sv =====
// Request channel into the decode stage: write-back or decode requests.
interface rvds_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [rvds_pkg::XLEN-1:0]           instr_word;
  logic [rvds_pkg::XLEN-1:0]           pc_value;
  logic [rvds_pkg::REG_AW-1:0]         wb_reg;
  logic signed [rvds_pkg::XLEN-1:0]    wb_data;
  logic [rvds_pkg::NREG-1:0]           pending_writes;
  logic                                ext_hazard_rs1;
  logic                                ext_hazard_rs2;
  logic                                pipeline_empty;

  modport source (
    output valid, command, instr_word, pc_value, wb_reg, wb_data, pending_writes,
           ext_hazard_rs1, ext_hazard_rs2, pipeline_empty,
    input  ready
  );
  modport sink (
    input  valid, command, instr_word, pc_value, wb_reg, wb_data, pending_writes,
           ext_hazard_rs1, ext_hazard_rs2, pipeline_empty,
    output ready
  );
endinterface

// ===== sv/rvds_out_if.sv =====
// Result channel out of the decode stage.
interface rvds_out_if;
  logic                             valid;
  logic                             ready;
  logic                             stall_res;
  logic                             flush;
  logic [rvds_pkg::XLEN-1:0]        target_pc;
  logic signed [rvds_pkg::XLEN-1:0] operand_a;
  logic signed [rvds_pkg::XLEN-1:0] operand_b;
  logic signed [rvds_pkg::XLEN-1:0] store_value;
  logic [rvds_pkg::REG_AW-1:0]      dest_reg;
  logic                             write_enable;
  logic [4:0]                       alu_code;
  logic [3:0]                       mem_code;
  logic                             to_float_unit;
  logic                             illegal_op;

  modport source (
    output valid, stall_res, flush, target_pc, operand_a, operand_b, store_value,
           dest_reg, write_enable, alu_code, mem_code, to_float_unit, illegal_op,
    input  ready
  );
  modport sink (
    input  valid, stall_res, flush, target_pc, operand_a, operand_b, store_value,
           dest_reg, write_enable, alu_code, mem_code, to_float_unit, illegal_op,
    output ready
  );
endinterface

// ===== sv/rvds_regfile.sv =====
// Integer register file: one write port, two registered read ports, per-entry valid bits.
module rvds_regfile (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rvds_pkg::rf_wr_t              wr_i,
  input  logic                          rd_en_i,
  input  logic [rvds_pkg::REG_AW-1:0]   raddr1_i,
  input  logic [rvds_pkg::REG_AW-1:0]   raddr2_i,
  output logic [rvds_pkg::XLEN-1:0]     rdata1_o,
  output logic [rvds_pkg::XLEN-1:0]     rdata2_o
);

  logic [rvds_pkg::XLEN-1:0] mem_q [rvds_pkg::NREG];
  logic [rvds_pkg::NREG-1:0] valid_q;
  logic [rvds_pkg::XLEN-1:0] rd1_q, rd2_q;
  logic                      v1_q, v2_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd1_q <= mem_q[raddr1_i];
      rd2_q <= mem_q[raddr2_i];
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        v1_q <= valid_q[raddr1_i];
        v2_q <= valid_q[raddr2_i];
      end
    end
  end

  assign rdata1_o = v1_q ? rd1_q : '0;
  assign rdata2_o = v2_q ? rd2_q : '0;

endmodule

// ===== sv/rvds_decode.sv =====
// Combinational decode: immediates, op codes, operands, branch resolution, hazards.
module rvds_decode (
  input  rvds_pkg::dec_req_t req_i,
  output rvds_pkg::dec_res_t res_o
);

  logic [31:0] instr;
  logic [4:0]  opc;
  logic [2:0]  f3;
  logic [4:0]  rs1i, rs2i, rdi;
  logic [31:0] rs1, rs2;
  logic [31:0] imm_i, imm_s, imm_u, imm_j, imm_b;
  logic [31:0] opa, opb, target;
  logic [4:0]  dest, alu;
  logic [3:0]  mem;
  logic        we, use1, use2, jump, fence, flt, illegal;
  logic        h1, h2, stall, taken;

  assign instr = req_i.instr;
  assign opc   = instr[6:2];
  assign f3    = instr[14:12];
  assign rs1i  = instr[19:15];
  assign rs2i  = instr[24:20];
  assign rdi   = instr[11:7];
  assign rs1   = req_i.rs1_val;
  assign rs2   = req_i.rs2_val;

  assign imm_i = {{20{instr[31]}}, instr[31:20]};
  assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
  assign imm_u = {instr[31:12], 12'b0};
  assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
  assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};

  // Branch condition; funct3 2 and 3 never branch.
  always_comb begin
    case (f3)
      rvds_pkg::F3_BEQ:  taken = (rs1 == rs2);
      rvds_pkg::F3_BNE:  taken = (rs1 != rs2);
      rvds_pkg::F3_BLT:  taken = ($signed(rs1) < $signed(rs2));
      rvds_pkg::F3_BGE:  taken = ($signed(rs1) >= $signed(rs2));
      rvds_pkg::F3_BLTU: taken = (rs1 < rs2);
      rvds_pkg::F3_BGEU: taken = (rs1 >= rs2);
      default:           taken = 1'b0;
    endcase
  end

  always_comb begin
    opa     = '0;
    opb     = '0;
    dest    = rvds_pkg::REG_ZERO;
    alu     = rvds_pkg::ALU_ADD;
    mem     = rvds_pkg::MEM_NONE;
    target  = '0;
    we      = 1'b0;
    use1    = 1'b0;
    use2    = 1'b0;
    jump    = 1'b0;
    fence   = 1'b0;
    flt     = 1'b0;
    illegal = 1'b0;
    case (opc)
      rvds_pkg::OPC_LOAD: begin
        opa = rs1; opb = imm_i; dest = rdi; we = 1'b1; mem = {1'b0, f3}; use1 = 1'b1;
      end
      rvds_pkg::OPC_STORE, rvds_pkg::OPC_STORE_FP: begin
        opa  = rs1; opb = imm_s; dest = rdi;
        mem  = {1'b0, f3} | rvds_pkg::MEM_STORE;
        use1 = 1'b1; use2 = 1'b1;
        flt  = (opc == rvds_pkg::OPC_STORE_FP);
      end
      rvds_pkg::OPC_LOAD_FP: begin
        opa = rs1; opb = imm_i; dest = rdi; mem = {1'b0, f3}; use1 = 1'b1; flt = 1'b1;
      end
      rvds_pkg::OPC_OP_IMM: begin
        opa = rs1; opb = imm_i; dest = rdi; we = 1'b1; use1 = 1'b1;
        alu = {2'b00, f3};
        if (f3 == rvds_pkg::F3_SLL || f3 == rvds_pkg::F3_SRX) begin
          alu[3] = instr[30];
        end
      end
      rvds_pkg::OPC_OP: begin
        opa = rs1; opb = rs2; dest = rdi; we = 1'b1; use1 = 1'b1; use2 = 1'b1;
        alu = {instr[25], instr[30], f3};
      end
      rvds_pkg::OPC_LUI: begin
        opb = imm_u; dest = rdi; we = 1'b1; alu = rvds_pkg::ALU_OR;
      end
      rvds_pkg::OPC_AUIPC: begin
        opa = req_i.pc; opb = imm_u; dest = rdi; we = 1'b1;
      end
      rvds_pkg::OPC_JAL: begin
        target = req_i.pc + imm_j;
        jump = 1'b1; opa = req_i.pc; opb = rvds_pkg::LINK_STEP; dest = rdi; we = 1'b1;
      end
      rvds_pkg::OPC_JALR: begin
        target = (rs1 + imm_i) & ~32'd1;
        jump = 1'b1; opa = req_i.pc; opb = rvds_pkg::LINK_STEP; dest = rdi; we = 1'b1;
        use1 = 1'b1;
      end
      rvds_pkg::OPC_BRANCH: begin
        jump   = taken;
        target = taken ? (req_i.pc + imm_b) : '0;
        use1   = 1'b1; use2 = 1'b1;
      end
      rvds_pkg::OPC_MISC_MEM: begin
        fence = 1'b1;
      end
      rvds_pkg::OPC_SYSTEM: begin
        dest = rvds_pkg::REG_SYS;
      end
      rvds_pkg::OPC_OP_FP: begin
        opa = rs1; opb = rs2; dest = rdi; we = 1'b1; use1 = 1'b1; flt = 1'b1;
      end
      default: begin
        illegal = 1'b1;
      end
    endcase
  end

  assign h1 = use1 && (rs1i != rvds_pkg::REG_ZERO) && (req_i.pending[rs1i] || req_i.eh1);
  assign h2 = use2 && (rs2i != rvds_pkg::REG_ZERO) && (req_i.pending[rs2i] || req_i.eh2);
  assign stall = h1 || h2 || (fence && !req_i.empty);

  always_comb begin
    res_o.stall     = stall;
    res_o.flush     = 1'b0;
    res_o.target    = '0;
    res_o.opa       = opa;
    res_o.opb       = opb;
    res_o.store_val = rs2;
    res_o.dest      = dest;
    res_o.we        = we;
    res_o.alu       = alu;
    res_o.mem       = mem;
    res_o.flt       = flt;
    res_o.illegal   = illegal;
    if (stall) begin
      res_o.target = req_i.pc;
      res_o.alu    = rvds_pkg::ALU_ADD;
      res_o.mem    = rvds_pkg::MEM_NONE;
      res_o.we     = 1'b0;
    end else if (jump) begin
      res_o.flush  = 1'b1;
      res_o.target = target;
      res_o.alu    = rvds_pkg::ALU_ADD;
      res_o.mem    = rvds_pkg::MEM_NONE;
    end
  end

endmodule

// ===== sv/riscv_decode_stage_unit.sv =====
// Top level of the RISC-V decode stage: register file, input stage, decode and result register.
//
//  channel | dir | requests                                   | handshake
//  in_i    | in  | write-back (command 0) or decode (command 1) | valid/ready
//  out_o   | out | one result per decode request              | valid/ready
//
//  One request per clock unless a held result stalls the input stage. A decode request
//  fills the register file read and the input stage when it is taken; the decode logic
//  then fills the result register once that is free or drains. A write-back
//  writes the register file at the edge it is taken and gives no result.
//  Reset empties both stages and marks every register as zero; no clearing pass.
//  A stalled result holds the result register and, behind it, the input stage.
module riscv_decode_stage_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  rvds_in_if.sink           in_i,
  rvds_out_if.source        out_o
);

  // Input stage: the decode request waiting for its register read data.
  logic                          s1_valid_q;
  logic [rvds_pkg::XLEN-1:0]     s1_instr_q;
  logic [rvds_pkg::XLEN-1:0]     s1_pc_q;
  logic [rvds_pkg::NREG-1:0]     s1_pending_q;
  logic                          s1_eh1_q, s1_eh2_q, s1_empty_q;

  // Result register.
  logic                          out_valid_q;
  rvds_pkg::dec_res_t            res_q;

  logic                          in_fire, dec_fire, s1_move;
  rvds_pkg::rf_wr_t              rf_wr;
  logic [rvds_pkg::XLEN-1:0]     rs1_val, rs2_val;
  rvds_pkg::dec_req_t            dec_req;
  rvds_pkg::dec_res_t            dec_res;

  // The input stage moves on whenever the result register is free or drains.
  assign s1_move    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_move;
  assign in_fire    = in_i.valid && in_i.ready;
  assign dec_fire   = in_fire && in_i.command;

  // x0 is never written, so its valid bit stays clear and it reads zero.
  assign rf_wr.en   = in_fire && !in_i.command && (in_i.wb_reg != rvds_pkg::REG_ZERO);
  assign rf_wr.addr = in_i.wb_reg;
  assign rf_wr.data = in_i.wb_data;

  rvds_regfile u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (rf_wr),
    .rd_en_i  (dec_fire),
    .raddr1_i (in_i.instr_word[19:15]),
    .raddr2_i (in_i.instr_word[24:20]),
    .rdata1_o (rs1_val),
    .rdata2_o (rs2_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= dec_fire;
      end
      if (s1_move) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (dec_fire) begin
      s1_instr_q   <= in_i.instr_word;
      s1_pc_q      <= in_i.pc_value;
      s1_pending_q <= in_i.pending_writes;
      s1_eh1_q     <= in_i.ext_hazard_rs1;
      s1_eh2_q     <= in_i.ext_hazard_rs2;
      s1_empty_q   <= in_i.pipeline_empty;
    end
    if (s1_move && s1_valid_q) begin
      res_q <= dec_res;
    end
  end

  assign dec_req.instr   = s1_instr_q;
  assign dec_req.pc      = s1_pc_q;
  assign dec_req.rs1_val = rs1_val;
  assign dec_req.rs2_val = rs2_val;
  assign dec_req.pending = s1_pending_q;
  assign dec_req.eh1     = s1_eh1_q;
  assign dec_req.eh2     = s1_eh2_q;
  assign dec_req.empty   = s1_empty_q;

  rvds_decode u_decode (
    .req_i (dec_req),
    .res_o (dec_res)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.stall_res     = res_q.stall;
  assign out_o.flush         = res_q.flush;
  assign out_o.target_pc     = res_q.target;
  assign out_o.operand_a     = $signed(res_q.opa);
  assign out_o.operand_b     = $signed(res_q.opb);
  assign out_o.store_value   = $signed(res_q.store_val);
  assign out_o.dest_reg      = res_q.dest;
  assign out_o.write_enable  = res_q.we;
  assign out_o.alu_code      = res_q.alu;
  assign out_o.mem_code      = res_q.mem;
  assign out_o.to_float_unit = res_q.flt;
  assign out_o.illegal_op    = res_q.illegal;

endmodule

// ===== sv/rvds_checker.sv =====
// Port-level checks of the decode stage and their bind to the top level.
`include "riscv_decode_stage_unit_defines.svh"

module rvds_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       stall_i,
  input logic       flush_i,
  input logic       we_i,
  input logic [4:0] alu_i,
  input logic [3:0] mem_i,
  input logic [4:0] dest_i,
  input logic       illegal_i
);

  logic out_held, both_set, stall_seen, stall_quiet, illegal_seen, illegal_quiet;

  assign out_held      = out_valid_i && !out_ready_i;
  assign both_set      = stall_i && flush_i;
  assign stall_seen    = out_valid_i && stall_i;
  assign stall_quiet   = !we_i && (alu_i == rvds_pkg::ALU_ADD) && (mem_i == rvds_pkg::MEM_NONE);
  assign illegal_seen  = out_valid_i && illegal_i;
  assign illegal_quiet = !we_i && (dest_i == rvds_pkg::REG_ZERO)
                         && (mem_i == rvds_pkg::MEM_NONE) && !flush_i;

  `RVDS_ASSERT_IN_RST(a_no_result_in_reset, clk_i, rst_ni, !out_valid_i, "result during reset")

  `RVDS_ASSERT(a_valid_holds, clk_i, rst_ni, out_held |=> out_valid_i, "result dropped")

  `RVDS_ASSERT(a_stall_no_flush, clk_i, rst_ni, out_valid_i |-> !both_set, "stall with flush")

  `RVDS_ASSERT(a_stall_quiet, clk_i, rst_ni, stall_seen |-> stall_quiet, "stall not squashed")

  `RVDS_ASSERT(a_illegal_quiet, clk_i, rst_ni, illegal_seen |-> illegal_quiet, "illegal op acted")

endmodule

bind riscv_decode_stage_unit rvds_checker u_rvds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .stall_i     (out_o.stall_res),
  .flush_i     (out_o.flush),
  .we_i        (out_o.write_enable),
  .alu_i       (out_o.alu_code),
  .mem_i       (out_o.mem_code),
  .dest_i      (out_o.dest_reg),
  .illegal_i   (out_o.illegal_op)
);
